>>> hw/rtl/text_console_cursor_engine_top_defines.svh
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// Implication checked in the next cycle, ignored while reset is asserted.
`define TCCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked in the same cycle, ignored while reset is asserted.
`define TCCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, active during reset as well.
`define TCCE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tcce_pkg.sv
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Width of the position fields on the ports.
  localparam int POS_OUT_W = 11;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd15;

  localparam logic CMD_PUT       = 1'b0;
  localparam logic CMD_BACKSPACE = 1'b1;

  typedef struct packed {
    logic load_in;    // capture the input item
    logic exec;       // apply the item and load the result register
    logic clr_start;  // begin a clearing sweep with the current attribute
    logic clr_step;   // write one blank cell of the sweep
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_clear; // the captured item will push the cursor past the last row
    logic clr_last;   // the sweep is at the last cell
  } dp_status_t;

endpackage

>>> hw/rtl/tcce_ctrl.sv
`timescale 1ns / 1ps

module tcce_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tcce_pkg::dp_status_t status,
  output tcce_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The result register can take a new item if empty or drained at this edge.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.need_clear) begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLEAR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/tcce_datapath.sv
`timescale 1ns / 1ps

module tcce_datapath #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcce_pkg::ctrl_cmd_t                 cmd,
  output tcce_pkg::dp_status_t                status,
  input  logic                                cfg_write,
  input  logic [7:0]                          cfg_data,
  input  logic                                in_cmd,
  input  logic [7:0]                          in_char_code,
  input  logic [10:0]                         in_guard_position,
  output logic [tcce_pkg::POS_OUT_W-1:0]      out_cursor_position,
  output logic                                out_cell_written,
  output logic [tcce_pkg::POS_OUT_W-1:0]      out_cell_index,
  output logic [7:0]                          out_cell_char,
  output logic                                out_screen_cleared
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int PW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int CW    = (PW > tcce_pkg::POS_OUT_W) ? PW : tcce_pkg::POS_OUT_W;
  localparam int OW    = tcce_pkg::POS_OUT_W;

  logic [15:0]    screen_mem [CELLS];

  logic [7:0]     attr_r;
  logic [7:0]     clr_attr_r;
  logic [PW-1:0]  clr_idx_r;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CLW-1:0] col_r, col_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic           cmd_r;
  logic [7:0]     char_r;
  logic [10:0]    guard_r;

  logic           wr;
  logic [PW-1:0]  wr_idx;
  logic [7:0]     wr_char;
  logic           cleared;
  logic           is_put, is_nl, at_last_col, at_last_row, bs_ok;
  logic [PW+OW-1:0] pos_ext, idx_ext;

  assign is_put      = (cmd_r == tcce_pkg::CMD_PUT);
  assign is_nl       = (char_r == tcce_pkg::NEWLINE_CODE);
  assign at_last_col = (col_r == CLW'(COLUMNS - 1));
  assign at_last_row = (row_r == RW'(ROWS - 1));
  assign bs_ok       = (CW'(pos_r) > CW'(guard_r)) && (col_r != '0);

  assign status.need_clear = is_put && (is_nl || at_last_col) && at_last_row;
  assign status.clr_last   = (clr_idx_r == PW'(CELLS - 1));

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    pos_nxt = pos_r;
    wr      = 1'b0;
    wr_idx  = '0;
    wr_char = '0;
    cleared = 1'b0;
    if (is_put) begin
      if (is_nl) begin
        // Start of the next row: drop the column, add one row.
        pos_nxt = pos_r - PW'(col_r) + PW'(COLUMNS);
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        wr      = 1'b1;
        wr_idx  = pos_r;
        wr_char = char_r;
        pos_nxt = pos_r + PW'(1);
        if (at_last_col) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + CLW'(1);
        end
      end
      if (status.need_clear) begin
        row_nxt = '0;
        col_nxt = '0;
        pos_nxt = '0;
        cleared = 1'b1;
      end
    end else if (bs_ok) begin
      col_nxt = col_r - CLW'(1);
      pos_nxt = pos_r - PW'(1);
      wr      = 1'b1;
      wr_idx  = pos_r - PW'(1);
      wr_char = tcce_pkg::SPACE_CODE;
    end
  end

  assign pos_ext = {{OW{1'b0}}, pos_nxt};
  assign idx_ext = {{OW{1'b0}}, wr_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r     <= tcce_pkg::ATTR_RESET;
      clr_attr_r <= tcce_pkg::ATTR_RESET;
      clr_idx_r  <= '0;
      row_r      <= '0;
      col_r      <= '0;
      pos_r      <= '0;
    end else begin
      if (cfg_write) begin
        attr_r <= cfg_data;
      end
      if (cmd.exec) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
        pos_r <= pos_nxt;
      end
      // The sweep keeps the attribute that was current when it began.
      if (cmd.clr_start) begin
        clr_idx_r  <= '0;
        clr_attr_r <= attr_r;
      end else if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r   <= in_cmd;
      char_r  <= in_char_code;
      guard_r <= in_guard_position;
    end
    if (cmd.exec) begin
      out_cursor_position <= pos_ext[OW-1:0];
      out_cell_written    <= wr;
      out_cell_index      <= idx_ext[OW-1:0];
      out_cell_char       <= wr_char;
      out_screen_cleared  <= cleared;
    end
  end

  // Screen store: one write port shared by item writes and the clearing sweep.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr) begin
      screen_mem[wr_idx] <= {attr_r, wr_char};
    end else if (cmd.clr_step) begin
      screen_mem[clr_idx_r] <= {clr_attr_r, tcce_pkg::SPACE_CODE};
    end
  end

endmodule

>>> hw/rtl/text_console_cursor_engine_top.sv
`timescale 1ns / 1ps

// Text console cursor engine. An item is taken in the idle state and applied
// in the execute state, which waits while the result register is stalled by
// the sink. A put or newline that runs off the last row clears the screen
// store through its single write port, one cell per cycle, and blocks new
// input until that sweep is over; its result is already offered during the
// sweep. After reset the same sweep fills the store with blank cells, and no
// item is taken before it ends.
// The attribute register may be written at any time the engine is idle.
module text_console_cursor_engine_top #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [7:0]                     in_char_code,
  input  logic [10:0]                    in_guard_position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcce_pkg::POS_OUT_W-1:0] out_cursor_position,
  output logic                           out_cell_written,
  output logic [tcce_pkg::POS_OUT_W-1:0] out_cell_index,
  output logic [7:0]                     out_cell_char,
  output logic                           out_screen_cleared
);

  tcce_pkg::ctrl_cmd_t  cmd;
  tcce_pkg::dp_status_t status;

  tcce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tcce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_write           (cfg_write),
    .cfg_data            (cfg_data),
    .in_cmd              (in_cmd),
    .in_char_code        (in_char_code),
    .in_guard_position   (in_guard_position),
    .out_cursor_position (out_cursor_position),
    .out_cell_written    (out_cell_written),
    .out_cell_index      (out_cell_index),
    .out_cell_char       (out_cell_char),
    .out_screen_cleared  (out_screen_cleared)
  );

endmodule

>>> hw/rtl/tcce_checker.sv
`timescale 1ns / 1ps
`include "text_console_cursor_engine_top_defines.svh"

module tcce_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [tcce_pkg::POS_OUT_W-1:0] out_cursor_position,
  input logic                           out_screen_cleared
);

  // A result that is not taken stays offered.
  `TCCE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

  // One item at a time: right after an item is taken the input is busy.
  `TCCE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken while busy")

  // A cleared screen always leaves the cursor at home.
  `TCCE_ASSERT_NOW(a_clear_homes, clk, rst_n, out_valid && out_screen_cleared, out_cursor_position == '0, "clear without homing")

  // The clearing pass after reset holds off input.
  `TCCE_ASSERT_NEXT_ALWAYS(a_reset_sweep, clk, !rst_n, in_stall, "input open during reset sweep")

endmodule

bind text_console_cursor_engine_top tcce_checker u_tcce_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_cursor_position (out_cursor_position),
  .out_screen_cleared  (out_screen_cleared)
);

>>> tb/tb_text_console_cursor_engine_top.sv
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_top;

  localparam int COLUMNS        = tcce_pkg::COLUMNS_DEF;
  localparam int ROWS           = tcce_pkg::ROWS_DEF;
  localparam int CELLS          = COLUMNS * ROWS;
  localparam int SWEEP_SETTLE   = CELLS + 32;
  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int MAX_IDLE       = 13;
  localparam int GUARD_MAX      = 1999;
  localparam int POS_W          = tcce_pkg::POS_OUT_W;

  typedef struct packed {
    logic [POS_W-1:0] cursor_position;
    logic             cell_written;
    logic [POS_W-1:0] cell_index;
    logic [7:0]       cell_char;
    logic             screen_cleared;
  } cursor_report_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_write;
  logic [7:0]       cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic             in_cmd;
  logic [7:0]       in_char_code;
  logic [10:0]      in_guard_position;
  logic             out_valid;
  logic             out_stall;
  logic [POS_W-1:0] out_cursor_position;
  logic             out_cell_written;
  logic [POS_W-1:0] out_cell_index;
  logic [7:0]       out_cell_char;
  logic             out_screen_cleared;

  // Cursor as the console should hold it after each item.
  int unsigned    cur_row;
  int unsigned    cur_col;

  cursor_report_t cursor_reports_due[$];
  cursor_report_t arrived_want;
  int unsigned    error_count;
  int unsigned    sink_hold_request;
  bit             fast_source;
  bit             force_back_to_back;

  text_console_cursor_engine_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write          (cfg_write),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_char_code       (in_char_code),
    .in_guard_position  (in_guard_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cursor_position(out_cursor_position),
    .out_cell_written   (out_cell_written),
    .out_cell_index     (out_cell_index),
    .out_cell_char      (out_cell_char),
    .out_screen_cleared (out_screen_cleared)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned position_now();
    position_now = cur_row * COLUMNS + cur_col;
  endfunction

  function automatic cursor_report_t advance_cursor(input logic cmd, input logic [7:0] ch,
                                                    input logic [10:0] guard);
    cursor_report_t r;
    int unsigned    here;
    r    = '0;
    here = position_now();
    if (cmd == tcce_pkg::CMD_PUT) begin
      if (ch == tcce_pkg::NEWLINE_CODE) begin
        cur_col = 0;
        cur_row++;
      end else begin
        r.cell_written = 1'b1;
        r.cell_index   = here[POS_W-1:0];
        r.cell_char    = ch;
        cur_col++;
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      // Running off the last row blanks the screen and homes the cursor.
      if (cur_row >= ROWS) begin
        cur_row          = 0;
        cur_col          = 0;
        r.screen_cleared = 1'b1;
      end
    end else if (here > guard && cur_col != 0) begin
      cur_col--;
      here           = position_now();
      r.cell_written = 1'b1;
      r.cell_index   = here[POS_W-1:0];
      r.cell_char    = tcce_pkg::SPACE_CODE;
    end
    here              = position_now();
    r.cursor_position = here[POS_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string label, input logic [10:0] want_v,
                                      input logic [10:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, label, want_v, got_v);
      error_count++;
    end
  endfunction

  function automatic logic [10:0] rand_guard();
    rand_guard = 11'($urandom_range(0, GUARD_MAX));
  endfunction

  function automatic logic [7:0] rand_char(input int unsigned lo);
    rand_char = 8'($urandom_range(lo, 255));
  endfunction

  function automatic logic [10:0] pick_guard();
    int unsigned here;
    here = position_now();
    case ($urandom_range(0, 4))
      0:       pick_guard = 11'(here);
      1:       pick_guard = (here == 0) ? 11'd0 : 11'(here - 1);
      2:       pick_guard = rand_guard();
      default: pick_guard = 11'($urandom_range(0, 15));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cursor_reports_due.size() == 0) begin
        $display("%0t: unexpected item, expected none, got cursor_position %0d", $time,
                 out_cursor_position);
        error_count++;
      end else begin
        arrived_want = cursor_reports_due.pop_front();
        check_field("cursor_position", arrived_want.cursor_position, out_cursor_position);
        check_field("cell_written", 11'(arrived_want.cell_written), 11'(out_cell_written));
        check_field("cell_index", arrived_want.cell_index, out_cell_index);
        check_field("cell_char", 11'(arrived_want.cell_char), 11'(out_cell_char));
        check_field("screen_cleared", 11'(arrived_want.screen_cleared),
                    11'(out_screen_cleared));
      end
    end
  end

  // The sink stalls for a random count after each item, with stretches of no stalls,
  // and for a long stretch whenever a test asks for one.
  initial begin : sink_ctrl
    int unsigned stall_left;
    int unsigned hold_left;
    bit          fast_sink;
    stall_left = 0;
    hold_left  = 0;
    fast_sink  = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_request != 0) begin
        hold_left         = sink_hold_request;
        sink_hold_request = 0;
      end
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if ($urandom_range(0, 15) == 0) fast_sink = !fast_sink;
        stall_left = fast_sink ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] ch, input logic [10:0] guard);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) fast_source = !fast_source;
    gap = (fast_source || force_back_to_back) ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= cmd;
    in_char_code      <= ch;
    in_guard_position <= guard;
    do @(posedge clk); while (in_stall);
    cursor_reports_due.push_back(advance_cursor(cmd, ch, guard));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (cursor_reports_due.size() != 0);
  endtask

  // A screen clear keeps sweeping after its item has come back, so the attribute
  // is only changed once that sweep must be over.
  task automatic set_attribute(input logic [7:0] value);
    drain_results();
    repeat (SWEEP_SETTLE) @(posedge clk);
    cfg_data  <= value;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75)
      send_item(tcce_pkg::CMD_PUT, rand_char(0), rand_guard());
    else if (pick < 85)
      send_item(tcce_pkg::CMD_PUT, tcce_pkg::NEWLINE_CODE, rand_guard());
    else
      send_item(tcce_pkg::CMD_BACKSPACE, rand_char(0), pick_guard());
  endtask

  task automatic test_directed();
    send_item(tcce_pkg::CMD_BACKSPACE, 8'h00, 11'd0);       // refused at column 0 of home
    send_item(tcce_pkg::CMD_PUT, 8'h00, 11'd0);
    send_item(tcce_pkg::CMD_PUT, 8'hFF, 11'd2047 - 11'd48);
    send_item(tcce_pkg::CMD_PUT, "A", 11'd0);
    send_item(tcce_pkg::CMD_BACKSPACE, 8'hFF, 11'(GUARD_MAX)); // position below the guard
    send_item(tcce_pkg::CMD_BACKSPACE, 8'h00, 11'd3);       // position equal to the guard
    send_item(tcce_pkg::CMD_BACKSPACE, 8'h00, 11'd2);
    send_item(tcce_pkg::CMD_PUT, tcce_pkg::NEWLINE_CODE, 11'd0);
    send_item(tcce_pkg::CMD_PUT, 8'h80, 11'd0);
    send_item(tcce_pkg::CMD_PUT, 8'h7F, 11'd0);
    send_item(tcce_pkg::CMD_PUT, 8'h55, 11'd0);
    send_item(tcce_pkg::CMD_PUT, 8'hAA, 11'd0);
    repeat (4) send_item(tcce_pkg::CMD_BACKSPACE, 8'h20, 11'd0);
    // Back at column 0 of a lower row: refused even though above the guard.
    send_item(tcce_pkg::CMD_BACKSPACE, 8'h20, 11'd0);
    send_item(tcce_pkg::CMD_PUT, tcce_pkg::NEWLINE_CODE, 11'd1024);
    send_item(tcce_pkg::CMD_PUT, tcce_pkg::NEWLINE_CODE, 11'd0);
  endtask

  // Walk to the last cell, fill it to force a clear, then clear again by newlines.
  task automatic test_screen_end();
    while (cur_row != ROWS - 1)
      send_item(tcce_pkg::CMD_PUT, tcce_pkg::NEWLINE_CODE, rand_guard());
    while (cur_col != COLUMNS - 1)
      send_item(tcce_pkg::CMD_PUT, rand_char(11), rand_guard());
    send_item(tcce_pkg::CMD_PUT, rand_char(11), rand_guard());
    repeat (ROWS) send_item(tcce_pkg::CMD_PUT, tcce_pkg::NEWLINE_CODE, rand_guard());
  endtask

  // Lines of text of random length, some long enough to wrap, with edits and noise.
  task automatic test_random_text(input int unsigned item_total);
    int unsigned sent;
    int unsigned line_len;
    int unsigned k;
    sent = 0;
    while (sent < item_total) begin
      line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 40);
      for (k = 0; k < line_len && sent < item_total; k++) begin
        if ($urandom_range(0, 99) < 85)
          send_item(tcce_pkg::CMD_PUT, rand_char(0), rand_guard());
        else
          send_item(tcce_pkg::CMD_BACKSPACE, rand_char(0), pick_guard());
        sent++;
      end
      send_item(tcce_pkg::CMD_PUT, tcce_pkg::NEWLINE_CODE, rand_guard());
      sent++;
      if ($urandom_range(0, 9) == 0) begin
        random_item();
        sent++;
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end
  endtask

  // Hold the sink off long enough that the engine fills and stalls its input.
  task automatic test_output_backpressure();
    int unsigned k;
    sink_hold_request  = 400;
    force_back_to_back = 1'b1;
    for (k = 0; k < 24; k++) random_item();
    force_back_to_back = 1'b0;
    drain_results();
    for (k = 0; k < 16; k++) random_item();
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_write         <= 1'b0;
    cfg_data          <= 8'h00;
    in_valid          <= 1'b0;
    in_cmd            <= tcce_pkg::CMD_PUT;
    in_char_code      <= 8'h00;
    in_guard_position <= 11'd0;
    sink_hold_request  = 0;
    fast_source        = 1'b0;
    force_back_to_back = 1'b0;
    error_count        = 0;
    cur_row            = 0;
    cur_col            = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_attribute(8'h00);
    test_directed();
    set_attribute(8'hFF);
    test_screen_end();
    set_attribute(8'($urandom_range(1, 254)));
    test_random_text(700);
    set_attribute(tcce_pkg::ATTR_RESET);
    test_output_backpressure();
    set_attribute(8'($urandom_range(0, 255)));
    test_random_text(560);

    drain_results();
    repeat (SWEEP_SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
